FILE: rtl/smsq_pkg.sv
// Shared types, codes and constants of the sensor driven move sequencer.
// No dependencies; every other file takes names from here by scope.
package smsq_pkg;

  localparam int unsigned CfgIdxW = 4;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_LF_THR       = 4'd0;
  localparam cfg_idx_t CFG_RF_THR       = 4'd1;
  localparam cfg_idx_t CFG_REAR_THR     = 4'd2;
  localparam cfg_idx_t CFG_ESC_STRAIGHT = 4'd3;
  localparam cfg_idx_t CFG_ESC_SIDE     = 4'd4;
  localparam cfg_idx_t CFG_SEARCH       = 4'd5;
  localparam cfg_idx_t CFG_ROTATE       = 4'd6;
  localparam cfg_idx_t CFG_ATTACK       = 4'd7;

  typedef logic [3:0] move_t;

  localparam move_t MOVE_HALT       = 4'd0;
  localparam move_t MOVE_FWD        = 4'd1;
  localparam move_t MOVE_BACK       = 4'd2;
  localparam move_t MOVE_RIGHT_FWD  = 4'd3;
  localparam move_t MOVE_RIGHT_BACK = 4'd4;
  localparam move_t MOVE_LEFT_FWD   = 4'd5;
  localparam move_t MOVE_LEFT_BACK  = 4'd6;
  localparam move_t MOVE_ROT_RIGHT  = 4'd7;
  localparam move_t MOVE_ROT_LEFT   = 4'd8;
  localparam move_t MOVE_CHARGE     = 4'd9;

  typedef logic [1:0] drv_t;

  localparam drv_t DRV_STOP = 2'd0;
  localparam drv_t DRV_FWD  = 2'd1;
  localparam drv_t DRV_BACK = 2'd2;

  localparam logic [6:0] SEARCH_POWER    = 7'd50;
  localparam logic [6:0] CHARGE_POWER    = 7'd60;
  localparam logic [7:0] WANDER_BASE     = 8'd10;
  localparam logic [5:0] WANDER_SPAN_MAX = 6'd39;

  typedef struct packed {
    logic [7:0] lf_thr;
    logic [7:0] rf_thr;
    logic [7:0] rear_thr;
    logic [7:0] esc_straight;
    logic [7:0] esc_side;
    logic [7:0] search;
    logic [7:0] rotate;
    logic [7:0] attack;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    lf_thr:       8'd35,
    rf_thr:       8'd35,
    rear_thr:     8'd45,
    esc_straight: 8'd200,
    esc_side:     8'd10,
    search:       8'd30,
    rotate:       8'd70,
    attack:       8'd10
  };

  typedef struct packed {
    logic       line_fl;
    logic       line_fr;
    logic       line_rl;
    logic       line_rr;
    logic [7:0] range_fl;
    logic [7:0] range_fr;
    logic [7:0] range_rear;
    logic [2:0] move_pick;
    logic [5:0] time_pick;
  } in_item_t;

  typedef struct packed {
    drv_t m1;
    drv_t m2;
    drv_t s1;
    drv_t s2;
  } drive_set_t;

  typedef struct packed {
    move_t      move_code;
    drive_set_t drv;
    logic [6:0] power;
    logic [7:0] ticks;
  } out_item_t;

  function automatic drive_set_t drive_of(move_t mv);
    drive_set_t d;
    unique case (mv)
      MOVE_FWD:        d = '{DRV_FWD,  DRV_FWD,  DRV_FWD,  DRV_BACK};
      MOVE_BACK:       d = '{DRV_BACK, DRV_BACK, DRV_BACK, DRV_FWD};
      MOVE_RIGHT_FWD:  d = '{DRV_FWD,  DRV_STOP, DRV_FWD,  DRV_STOP};
      MOVE_RIGHT_BACK: d = '{DRV_BACK, DRV_STOP, DRV_BACK, DRV_STOP};
      MOVE_LEFT_FWD:   d = '{DRV_STOP, DRV_FWD,  DRV_STOP, DRV_BACK};
      MOVE_LEFT_BACK:  d = '{DRV_STOP, DRV_BACK, DRV_STOP, DRV_FWD};
      MOVE_ROT_RIGHT:  d = '{DRV_FWD,  DRV_BACK, DRV_FWD,  DRV_FWD};
      MOVE_ROT_LEFT:   d = '{DRV_BACK, DRV_FWD,  DRV_BACK, DRV_BACK};
      MOVE_CHARGE:     d = '{DRV_FWD,  DRV_FWD,  DRV_FWD,  DRV_BACK};
      default:         d = '{DRV_STOP, DRV_STOP, DRV_STOP, DRV_STOP};
    endcase
    return d;
  endfunction

endpackage

FILE: rtl/smsq_cfg_regs.sv
// Configuration register bank: thresholds and move durations.
// Depends on smsq_pkg for the register codes and reset values.
module smsq_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  smsq_pkg::cfg_idx_t cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              cfg_ready,
  output smsq_pkg::cfg_t    cfg
);

  smsq_pkg::cfg_t cfg_r;
  smsq_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        smsq_pkg::CFG_LF_THR:       cfg_nxt.lf_thr       = cfg_data;
        smsq_pkg::CFG_RF_THR:       cfg_nxt.rf_thr       = cfg_data;
        smsq_pkg::CFG_REAR_THR:     cfg_nxt.rear_thr     = cfg_data;
        smsq_pkg::CFG_ESC_STRAIGHT: cfg_nxt.esc_straight = cfg_data;
        smsq_pkg::CFG_ESC_SIDE:     cfg_nxt.esc_side     = cfg_data;
        smsq_pkg::CFG_SEARCH:       cfg_nxt.search       = cfg_data;
        smsq_pkg::CFG_ROTATE:       cfg_nxt.rotate       = cfg_data;
        smsq_pkg::CFG_ATTACK:       cfg_nxt.attack       = cfg_data;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= smsq_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/smsq_in_reg.sv
// Input register for one control tick request; stalls upstream only when
// the held request cannot move into the core.
// Depends on smsq_pkg for the request type.
module smsq_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  smsq_pkg::in_item_t in_item,
  output logic               in_stall,
  input  logic               item_take,
  output logic               item_vld,
  output smsq_pkg::in_item_t item
);

  logic               vld_r;
  logic               vld_nxt;
  smsq_pkg::in_item_t item_r;
  logic               load;

  assign in_stall = vld_r && !item_take;
  assign load     = in_valid && !in_stall;
  assign item_vld = vld_r;
  assign item     = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (item_take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: rtl/smsq_core.sv
// Move priority logic, move state and result register.
// Depends on smsq_pkg for types, move codes and the drive decoder.
module smsq_core (
  input  logic                clk,
  input  logic                rst_n,
  input  smsq_pkg::cfg_t      cfg,
  input  logic                item_vld,
  input  smsq_pkg::in_item_t  item,
  output logic                item_take,
  input  logic                out_stall,
  output logic                out_vld,
  output smsq_pkg::out_item_t out_item
);

  smsq_pkg::move_t     move_r;
  smsq_pkg::move_t     move_nxt;
  logic [7:0]          ticks_r;
  logic [7:0]          ticks_nxt;
  logic [6:0]          power_r;
  logic [6:0]          power_nxt;
  logic                out_vld_r;
  logic                out_vld_nxt;
  smsq_pkg::out_item_t out_r;
  smsq_pkg::out_item_t res;

  logic                any_line;
  logic                seen_l;
  logic                seen_r;
  logic                seen_b;
  logic                pick_en;
  smsq_pkg::move_t     pick_mv;
  logic [7:0]          pick_ticks;
  logic [5:0]          tp;
  smsq_pkg::move_t     run_mv;
  logic [7:0]          run_ticks;

  assign item_take = item_vld && (!out_vld_r || !out_stall);
  assign out_vld   = out_vld_r;
  assign out_item  = out_r;

  assign any_line = item.line_fl || item.line_fr || item.line_rl || item.line_rr;
  assign seen_l   = item.range_fl > cfg.lf_thr;
  assign seen_r   = item.range_fr > cfg.rf_thr;
  assign seen_b   = item.range_rear > cfg.rear_thr;
  assign tp       = (item.time_pick > smsq_pkg::WANDER_SPAN_MAX) ?
                    smsq_pkg::WANDER_SPAN_MAX : item.time_pick;

  always_comb begin
    pick_en    = 1'b1;
    pick_mv    = smsq_pkg::MOVE_HALT;
    pick_ticks = 8'd0;
    if (any_line) begin
      if (item.line_fl && item.line_fr) begin
        pick_mv    = smsq_pkg::MOVE_BACK;
        pick_ticks = cfg.esc_straight;
      end else if (item.line_rl && item.line_rr) begin
        pick_mv    = smsq_pkg::MOVE_FWD;
        pick_ticks = cfg.esc_straight;
      end else if (item.line_fl) begin
        pick_mv    = smsq_pkg::MOVE_RIGHT_BACK;
        pick_ticks = cfg.esc_side;
      end else if (item.line_fr) begin
        pick_mv    = smsq_pkg::MOVE_LEFT_BACK;
        pick_ticks = cfg.esc_side;
      end else if (item.line_rl) begin
        pick_mv    = smsq_pkg::MOVE_RIGHT_FWD;
        pick_ticks = cfg.esc_side;
      end else begin
        pick_mv    = smsq_pkg::MOVE_LEFT_FWD;
        pick_ticks = cfg.esc_side;
      end
    end else if (seen_l || seen_r || seen_b) begin
      if (seen_l && seen_r) begin
        pick_mv    = smsq_pkg::MOVE_CHARGE;
        pick_ticks = cfg.attack;
      end else if (seen_l) begin
        pick_mv    = smsq_pkg::MOVE_LEFT_FWD;
        pick_ticks = cfg.search;
      end else if (seen_r) begin
        pick_mv    = smsq_pkg::MOVE_RIGHT_FWD;
        pick_ticks = cfg.search;
      end else begin
        pick_mv    = smsq_pkg::MOVE_ROT_RIGHT;
        pick_ticks = cfg.rotate;
      end
    end else if (move_r == smsq_pkg::MOVE_HALT) begin
      pick_mv    = smsq_pkg::move_t'({1'b0, item.move_pick} + 4'd1);
      pick_ticks = smsq_pkg::WANDER_BASE + {2'b00, tp};
    end else begin
      pick_en = 1'b0;
    end
  end

  always_comb begin
    run_mv    = pick_en ? pick_mv : move_r;
    run_ticks = pick_en ? pick_ticks : ticks_r;
    // expired or unknown codes fall back to stop
    if (run_ticks == 8'd0 || run_mv > smsq_pkg::MOVE_CHARGE) begin
      run_mv = smsq_pkg::MOVE_HALT;
    end
    power_nxt = power_r;
    if (run_mv == smsq_pkg::MOVE_CHARGE) begin
      power_nxt = smsq_pkg::CHARGE_POWER;
    end else if (run_mv != smsq_pkg::MOVE_HALT) begin
      power_nxt = smsq_pkg::SEARCH_POWER;
    end
    ticks_nxt = (run_ticks != 8'd0) ? run_ticks - 8'd1 : 8'd0;
    move_nxt  = run_mv;

    res.move_code = run_mv;
    res.drv       = smsq_pkg::drive_of(run_mv);
    res.power     = power_nxt;
    res.ticks     = ticks_nxt;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (item_take) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_r    <= smsq_pkg::MOVE_HALT;
      ticks_r   <= 8'd0;
      power_r   <= 7'd0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (item_take) begin
        move_r  <= move_nxt;
        ticks_r <= ticks_nxt;
        power_r <= power_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      out_r <= res;
    end
  end

endmodule

FILE: rtl/sensor_driven_move_sequencer_unit.sv
// Sensor driven move sequencer: one control tick request in, one move
// result out. Built from smsq_cfg_regs, smsq_in_reg and smsq_core.
//
// Each accepted tick request yields exactly one result. The request waits in
// the input register until the result register is free, while the move logic
// computes the value that the result register takes at the next edge. A new
// request is taken every cycle while the output is not stalled; the rate is
// set by the update of the move state (move, remaining ticks, held
// power), which every tick reads and writes. The input
// stalls only while both the input and the result register hold a request
// and the output is stalled. Line sensors take priority over distance
// sensors, which take priority over a random wandering move chosen only
// while stopped. Configuration writes (index 0..7, higher indexes ignored)
// are always ready and should be made while no tick request is in flight.
module sensor_driven_move_sequencer_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_line_front_left,
  input  logic                      in_line_front_right,
  input  logic                      in_line_rear_left,
  input  logic                      in_line_rear_right,
  input  logic [7:0]                in_range_front_left,
  input  logic [7:0]                in_range_front_right,
  input  logic [7:0]                in_range_rear,
  input  logic [2:0]                in_random_move_pick,
  input  logic [5:0]                in_random_time_pick,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [3:0]                out_move_code,
  output logic [1:0]                out_motor_one_drive,
  output logic [1:0]                out_motor_two_drive,
  output logic [1:0]                out_servo_one_drive,
  output logic [1:0]                out_servo_two_drive,
  output logic [6:0]                out_motor_power,
  output logic [7:0]                out_ticks_remaining,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [smsq_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [7:0]                cfg_data
);

  smsq_pkg::cfg_t      cfg;
  smsq_pkg::in_item_t  in_item;
  smsq_pkg::in_item_t  item;
  logic                item_vld;
  logic                item_take;
  smsq_pkg::out_item_t out_item;

  assign in_item.line_fl    = in_line_front_left;
  assign in_item.line_fr    = in_line_front_right;
  assign in_item.line_rl    = in_line_rear_left;
  assign in_item.line_rr    = in_line_rear_right;
  assign in_item.range_fl   = in_range_front_left;
  assign in_item.range_fr   = in_range_front_right;
  assign in_item.range_rear = in_range_rear;
  assign in_item.move_pick  = in_random_move_pick;
  assign in_item.time_pick  = in_random_time_pick;

  smsq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  smsq_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .item_take (item_take),
    .item_vld  (item_vld),
    .item      (item)
  );

  smsq_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .item_vld  (item_vld),
    .item      (item),
    .item_take (item_take),
    .out_stall (out_stall),
    .out_vld   (out_valid),
    .out_item  (out_item)
  );

  assign out_move_code       = out_item.move_code;
  assign out_motor_one_drive = out_item.drv.m1;
  assign out_motor_two_drive = out_item.drv.m2;
  assign out_servo_one_drive = out_item.drv.s1;
  assign out_servo_two_drive = out_item.drv.s2;
  assign out_motor_power     = out_item.power;
  assign out_ticks_remaining = out_item.ticks;

endmodule

FILE: rtl/smsq_checker.sv
// Port-level checks for the move sequencer, bound to the top level.
// Depends on smsq_pkg for move and drive codes.
module smsq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_move_code,
  input logic [1:0] out_motor_one_drive,
  input logic [1:0] out_motor_two_drive,
  input logic [1:0] out_servo_one_drive,
  input logic [1:0] out_servo_two_drive,
  input logic [6:0] out_motor_power,
  input logic [7:0] out_ticks_remaining
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_move_code)
      && $stable(out_ticks_remaining) && $stable(out_motor_power))
    else $error("stalled result changed");

  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without a stalled result");

  a_stop_drives: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_code == smsq_pkg::MOVE_HALT |->
      out_motor_one_drive == smsq_pkg::DRV_STOP
      && out_motor_two_drive == smsq_pkg::DRV_STOP
      && out_servo_one_drive == smsq_pkg::DRV_STOP
      && out_servo_two_drive == smsq_pkg::DRV_STOP)
    else $error("stop result drives a motor");

  a_charge_power: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_move_code == smsq_pkg::MOVE_CHARGE |->
      out_motor_power == smsq_pkg::CHARGE_POWER)
    else $error("attack without attack power");

  a_move_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_move_code <= smsq_pkg::MOVE_CHARGE)
    else $error("move code out of range");

endmodule

bind sensor_driven_move_sequencer_unit smsq_checker u_smsq_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_move_code       (out_move_code),
  .out_motor_one_drive (out_motor_one_drive),
  .out_motor_two_drive (out_motor_two_drive),
  .out_servo_one_drive (out_servo_one_drive),
  .out_servo_two_drive (out_servo_two_drive),
  .out_motor_power     (out_motor_power),
  .out_ticks_remaining (out_ticks_remaining)
);

FILE: sim/sensor_driven_move_sequencer_unit_test.sv
`timescale 1ns / 1ps
// Testbench for sensor_driven_move_sequencer_unit: directed tick tables, then random ticks
// over several register settings, each result checked against a typed expectation or a local move predictor.
// Depends on smsq_pkg and the unit itself.
module sensor_driven_move_sequencer_unit_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;
  localparam int HOLD_AT        = 300;
  localparam int RAND_PHASES    = 6;
  localparam int PHASE_TICKS    = 170;
  localparam int PRINT_CAP      = 100;

  typedef struct {
    smsq_pkg::in_item_t  stim;
    bit                  typed;
    smsq_pkg::out_item_t want;
  } tick_row_t;

  // motor1, motor2, servo1, servo2 per move code
  localparam smsq_pkg::drive_set_t DRIVE_LUT [10] = '{
    {smsq_pkg::DRV_STOP, smsq_pkg::DRV_STOP, smsq_pkg::DRV_STOP, smsq_pkg::DRV_STOP},
    {smsq_pkg::DRV_FWD,  smsq_pkg::DRV_FWD,  smsq_pkg::DRV_FWD,  smsq_pkg::DRV_BACK},
    {smsq_pkg::DRV_BACK, smsq_pkg::DRV_BACK, smsq_pkg::DRV_BACK, smsq_pkg::DRV_FWD},
    {smsq_pkg::DRV_FWD,  smsq_pkg::DRV_STOP, smsq_pkg::DRV_FWD,  smsq_pkg::DRV_STOP},
    {smsq_pkg::DRV_BACK, smsq_pkg::DRV_STOP, smsq_pkg::DRV_BACK, smsq_pkg::DRV_STOP},
    {smsq_pkg::DRV_STOP, smsq_pkg::DRV_FWD,  smsq_pkg::DRV_STOP, smsq_pkg::DRV_BACK},
    {smsq_pkg::DRV_STOP, smsq_pkg::DRV_BACK, smsq_pkg::DRV_STOP, smsq_pkg::DRV_FWD},
    {smsq_pkg::DRV_FWD,  smsq_pkg::DRV_BACK, smsq_pkg::DRV_FWD,  smsq_pkg::DRV_FWD},
    {smsq_pkg::DRV_BACK, smsq_pkg::DRV_FWD,  smsq_pkg::DRV_BACK, smsq_pkg::DRV_BACK},
    {smsq_pkg::DRV_FWD,  smsq_pkg::DRV_FWD,  smsq_pkg::DRV_FWD,  smsq_pkg::DRV_BACK}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_line_front_left = 1'b0;
  logic               in_line_front_right = 1'b0;
  logic               in_line_rear_left = 1'b0;
  logic               in_line_rear_right = 1'b0;
  logic [7:0]         in_range_front_left = '0;
  logic [7:0]         in_range_front_right = '0;
  logic [7:0]         in_range_rear = '0;
  logic [2:0]         in_random_move_pick = '0;
  logic [5:0]         in_random_time_pick = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         out_move_code;
  logic [1:0]         out_motor_one_drive;
  logic [1:0]         out_motor_two_drive;
  logic [1:0]         out_servo_one_drive;
  logic [1:0]         out_servo_two_drive;
  logic [6:0]         out_motor_power;
  logic [7:0]         out_ticks_remaining;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  smsq_pkg::cfg_idx_t cfg_index = '0;
  logic [7:0]         cfg_data = '0;

  sensor_driven_move_sequencer_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_line_front_left   (in_line_front_left),
    .in_line_front_right  (in_line_front_right),
    .in_line_rear_left    (in_line_rear_left),
    .in_line_rear_right   (in_line_rear_right),
    .in_range_front_left  (in_range_front_left),
    .in_range_front_right (in_range_front_right),
    .in_range_rear        (in_range_rear),
    .in_random_move_pick  (in_random_move_pick),
    .in_random_time_pick  (in_random_time_pick),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_move_code        (out_move_code),
    .out_motor_one_drive  (out_motor_one_drive),
    .out_motor_two_drive  (out_motor_two_drive),
    .out_servo_one_drive  (out_servo_one_drive),
    .out_servo_two_drive  (out_servo_two_drive),
    .out_motor_power      (out_motor_power),
    .out_ticks_remaining  (out_ticks_remaining),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // move predictor state
  smsq_pkg::cfg_t  regs_now = smsq_pkg::CFG_RESET;
  smsq_pkg::move_t cur_move = smsq_pkg::MOVE_HALT;
  logic [7:0]      ticks_left = '0;
  logic [6:0]      held_power = '0;

  smsq_pkg::out_item_t pending_moves [$];
  int        errors = 0;
  int        ticks_sent = 0;
  int        results_checked = 0;
  int        settings_run = 1;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  int        quiet_cycles = 0;

  function automatic void launch_move(smsq_pkg::move_t mv, logic [7:0] dur);
    cur_move   = mv;
    ticks_left = dur;
  endfunction

  function automatic smsq_pkg::out_item_t predict_tick(smsq_pkg::in_item_t it);
    smsq_pkg::out_item_t r;
    logic                sl, sr, sb;
    logic [5:0]          tp;
    sl = it.range_fl > regs_now.lf_thr;
    sr = it.range_fr > regs_now.rf_thr;
    sb = it.range_rear > regs_now.rear_thr;
    if (it.line_fl || it.line_fr || it.line_rl || it.line_rr) begin
      if (it.line_fl && it.line_fr)
        launch_move(smsq_pkg::MOVE_BACK, regs_now.esc_straight);
      else if (it.line_rl && it.line_rr)
        launch_move(smsq_pkg::MOVE_FWD, regs_now.esc_straight);
      else if (it.line_fl) launch_move(smsq_pkg::MOVE_RIGHT_BACK, regs_now.esc_side);
      else if (it.line_fr) launch_move(smsq_pkg::MOVE_LEFT_BACK, regs_now.esc_side);
      else if (it.line_rl) launch_move(smsq_pkg::MOVE_RIGHT_FWD, regs_now.esc_side);
      else launch_move(smsq_pkg::MOVE_LEFT_FWD, regs_now.esc_side);
    end else if (sl || sr || sb) begin
      if (sl && sr) launch_move(smsq_pkg::MOVE_CHARGE, regs_now.attack);
      else if (sl) launch_move(smsq_pkg::MOVE_LEFT_FWD, regs_now.search);
      else if (sr) launch_move(smsq_pkg::MOVE_RIGHT_FWD, regs_now.search);
      else launch_move(smsq_pkg::MOVE_ROT_RIGHT, regs_now.rotate);
    end else if (cur_move == smsq_pkg::MOVE_HALT) begin
      tp = (it.time_pick > smsq_pkg::WANDER_SPAN_MAX) ?
           smsq_pkg::WANDER_SPAN_MAX : it.time_pick;
      launch_move(smsq_pkg::move_t'(it.move_pick) + smsq_pkg::move_t'(1),
                  smsq_pkg::WANDER_BASE + 8'(tp));
    end
    if (ticks_left == 0) cur_move = smsq_pkg::MOVE_HALT;
    if (cur_move > smsq_pkg::MOVE_CHARGE) cur_move = smsq_pkg::MOVE_HALT;
    if (cur_move == smsq_pkg::MOVE_CHARGE) held_power = smsq_pkg::CHARGE_POWER;
    else if (cur_move != smsq_pkg::MOVE_HALT) held_power = smsq_pkg::SEARCH_POWER;
    if (ticks_left != 0) ticks_left = ticks_left - 8'd1;
    r.move_code = cur_move;
    r.drv       = DRIVE_LUT[cur_move];
    r.power     = held_power;
    r.ticks     = ticks_left;
    return r;
  endfunction

  function automatic smsq_pkg::in_item_t mk_tick(bit fl, bit fr, bit rl, bit rr,
                                       logic [7:0] dl, logic [7:0] dr, logic [7:0] db,
                                       logic [2:0] mp, logic [5:0] tp);
    smsq_pkg::in_item_t it;
    it.line_fl    = fl;
    it.line_fr    = fr;
    it.line_rl    = rl;
    it.line_rr    = rr;
    it.range_fl   = dl;
    it.range_fr   = dr;
    it.range_rear = db;
    it.move_pick  = mp;
    it.time_pick  = tp;
    return it;
  endfunction

  function automatic smsq_pkg::out_item_t mk_res(smsq_pkg::move_t mv,
                                                 smsq_pkg::drive_set_t d,
                                                 logic [6:0] p, logic [7:0] t);
    smsq_pkg::out_item_t r;
    r.move_code = mv;
    r.drv       = d;
    r.power     = p;
    r.ticks     = t;
    return r;
  endfunction

  function automatic smsq_pkg::in_item_t gen_tick();
    smsq_pkg::in_item_t it;
    int                 r;
    r = $urandom_range(99);
    it.move_pick = 3'($urandom_range(7));
    it.time_pick = 6'($urandom_range(63));
    if (r < 25) begin
      {it.line_fl, it.line_fr, it.line_rl, it.line_rr} = 4'($urandom_range(15, 1));
      it.range_fl   = 8'($urandom);
      it.range_fr   = 8'($urandom);
      it.range_rear = 8'($urandom);
    end else begin
      {it.line_fl, it.line_fr, it.line_rl, it.line_rr} = 4'b0000;
      if (r < 55) begin
        it.range_fl   = 8'($urandom);
        it.range_fr   = 8'($urandom);
        it.range_rear = 8'($urandom);
      end else begin
        // nothing seen: lets timed moves run out and wandering start
        it.range_fl   = 8'($urandom_range(regs_now.lf_thr));
        it.range_fr   = 8'($urandom_range(regs_now.rf_thr));
        it.range_rear = 8'($urandom_range(regs_now.rear_thr));
      end
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= PRINT_CAP) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task automatic check_result;
    smsq_pkg::out_item_t want;
    if (pending_moves.size() == 0) begin
      report_mismatch($sformatf("move %0d arrived with no request pending", out_move_code));
      return;
    end
    want = pending_moves.pop_front();
    results_checked++;
    if (out_move_code !== want.move_code)
      report_mismatch($sformatf("move_code %0d, want %0d", out_move_code, want.move_code));
    if (out_motor_one_drive !== want.drv.m1)
      report_mismatch($sformatf("motor_one_drive %0d, want %0d", out_motor_one_drive,
                                want.drv.m1));
    if (out_motor_two_drive !== want.drv.m2)
      report_mismatch($sformatf("motor_two_drive %0d, want %0d", out_motor_two_drive,
                                want.drv.m2));
    if (out_servo_one_drive !== want.drv.s1)
      report_mismatch($sformatf("servo_one_drive %0d, want %0d", out_servo_one_drive,
                                want.drv.s1));
    if (out_servo_two_drive !== want.drv.s2)
      report_mismatch($sformatf("servo_two_drive %0d, want %0d", out_servo_two_drive,
                                want.drv.s2));
    if (out_motor_power !== want.power)
      report_mismatch($sformatf("motor_power %0d, want %0d", out_motor_power, want.power));
    if (out_ticks_remaining !== want.ticks)
      report_mismatch($sformatf("ticks_remaining %0d, want %0d", out_ticks_remaining,
                                want.ticks));
  endtask

  // result side: check, then choose next stall; one long hold-off to back up the unit
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_checked >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // expectation is queued while the request is offered, ahead of its registered result
  task automatic send_tick(input smsq_pkg::in_item_t it, input bit typed,
                           input smsq_pkg::out_item_t want);
    smsq_pkg::out_item_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_line_front_left   <= it.line_fl;
    in_line_front_right  <= it.line_fr;
    in_line_rear_left    <= it.line_rl;
    in_line_rear_right   <= it.line_rr;
    in_range_front_left  <= it.range_fl;
    in_range_front_right <= it.range_fr;
    in_range_rear        <= it.range_rear;
    in_random_move_pick  <= it.move_pick;
    in_random_time_pick  <= it.time_pick;
    pred = predict_tick(it);
    pending_moves.push_back(typed ? want : pred);
    ticks_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_program(input smsq_pkg::cfg_t c);
    smsq_pkg::cfg_idx_t idx_list [8];
    logic [7:0]         vals [8];
    idx_list = '{smsq_pkg::CFG_LF_THR, smsq_pkg::CFG_RF_THR, smsq_pkg::CFG_REAR_THR,
                 smsq_pkg::CFG_ESC_STRAIGHT, smsq_pkg::CFG_ESC_SIDE, smsq_pkg::CFG_SEARCH,
                 smsq_pkg::CFG_ROTATE, smsq_pkg::CFG_ATTACK};
    vals = '{c.lf_thr, c.rf_thr, c.rear_thr, c.esc_straight,
             c.esc_side, c.search, c.rotate, c.attack};
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    // index past the last register must be ignored
    cfg_index <= smsq_pkg::CFG_ATTACK + smsq_pkg::cfg_idx_t'($urandom_range(8, 1));
    cfg_data  <= 8'($urandom);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    regs_now = c;
    settings_run++;
  endtask

  initial begin
    tick_row_t           rows [$];
    smsq_pkg::cfg_t      c;
    smsq_pkg::out_item_t none;
    none = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 17;
    rx_idle_pct = 67;

    // reset settings: every escape, every sighting, wandering from stop
    rows.push_back('{mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      mk_res(smsq_pkg::MOVE_FWD,
             {smsq_pkg::DRV_FWD, smsq_pkg::DRV_FWD, smsq_pkg::DRV_FWD, smsq_pkg::DRV_BACK},
             smsq_pkg::SEARCH_POWER, 8'd9)});
    rows.push_back('{mk_tick(1, 1, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      mk_res(smsq_pkg::MOVE_BACK,
             {smsq_pkg::DRV_BACK, smsq_pkg::DRV_BACK, smsq_pkg::DRV_BACK, smsq_pkg::DRV_FWD},
             smsq_pkg::SEARCH_POWER, 8'd199)});
    rows.push_back('{mk_tick(0, 0, 1, 1, 0, 0, 0, 0, 0), 1'b1,
      mk_res(smsq_pkg::MOVE_FWD,
             {smsq_pkg::DRV_FWD, smsq_pkg::DRV_FWD, smsq_pkg::DRV_FWD, smsq_pkg::DRV_BACK},
             smsq_pkg::SEARCH_POWER, 8'd199)});
    rows.push_back('{mk_tick(1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      mk_res(smsq_pkg::MOVE_RIGHT_BACK,
             {smsq_pkg::DRV_BACK, smsq_pkg::DRV_STOP, smsq_pkg::DRV_BACK, smsq_pkg::DRV_STOP},
             smsq_pkg::SEARCH_POWER, 8'd9)});
    rows.push_back('{mk_tick(0, 1, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      mk_res(smsq_pkg::MOVE_LEFT_BACK,
             {smsq_pkg::DRV_STOP, smsq_pkg::DRV_BACK, smsq_pkg::DRV_STOP, smsq_pkg::DRV_FWD},
             smsq_pkg::SEARCH_POWER, 8'd9)});
    rows.push_back('{mk_tick(0, 0, 1, 0, 0, 0, 0, 0, 0), 1'b1,
      mk_res(smsq_pkg::MOVE_RIGHT_FWD,
             {smsq_pkg::DRV_FWD, smsq_pkg::DRV_STOP, smsq_pkg::DRV_FWD, smsq_pkg::DRV_STOP},
             smsq_pkg::SEARCH_POWER, 8'd9)});
    rows.push_back('{mk_tick(0, 0, 0, 1, 0, 0, 0, 0, 0), 1'b1,
      mk_res(smsq_pkg::MOVE_LEFT_FWD,
             {smsq_pkg::DRV_STOP, smsq_pkg::DRV_FWD, smsq_pkg::DRV_STOP, smsq_pkg::DRV_BACK},
             smsq_pkg::SEARCH_POWER, 8'd9)});
    rows.push_back('{mk_tick(1, 1, 1, 1, 255, 255, 255, 7, 63), 1'b1,
      mk_res(smsq_pkg::MOVE_BACK,
             {smsq_pkg::DRV_BACK, smsq_pkg::DRV_BACK, smsq_pkg::DRV_BACK, smsq_pkg::DRV_FWD},
             smsq_pkg::SEARCH_POWER, 8'd199)});
    rows.push_back('{mk_tick(0, 0, 0, 0, 36, 36, 0, 0, 0), 1'b1,
      mk_res(smsq_pkg::MOVE_CHARGE,
             {smsq_pkg::DRV_FWD, smsq_pkg::DRV_FWD, smsq_pkg::DRV_FWD, smsq_pkg::DRV_BACK},
             smsq_pkg::CHARGE_POWER, 8'd9)});
    rows.push_back('{mk_tick(0, 0, 0, 0, 255, 0, 0, 0, 0), 1'b1,
      mk_res(smsq_pkg::MOVE_LEFT_FWD,
             {smsq_pkg::DRV_STOP, smsq_pkg::DRV_FWD, smsq_pkg::DRV_STOP, smsq_pkg::DRV_BACK},
             smsq_pkg::SEARCH_POWER, 8'd29)});
    rows.push_back('{mk_tick(0, 0, 0, 0, 0, 255, 0, 0, 0), 1'b1,
      mk_res(smsq_pkg::MOVE_RIGHT_FWD,
             {smsq_pkg::DRV_FWD, smsq_pkg::DRV_STOP, smsq_pkg::DRV_FWD, smsq_pkg::DRV_STOP},
             smsq_pkg::SEARCH_POWER, 8'd29)});
    rows.push_back('{mk_tick(0, 0, 0, 0, 0, 0, 255, 0, 0), 1'b1,
      mk_res(smsq_pkg::MOVE_ROT_RIGHT,
             {smsq_pkg::DRV_FWD, smsq_pkg::DRV_BACK, smsq_pkg::DRV_FWD, smsq_pkg::DRV_FWD},
             smsq_pkg::SEARCH_POWER, 8'd69)});
    rows.push_back('{mk_tick(0, 0, 0, 0, 35, 35, 45, 7, 63), 1'b0, none});
    rows.push_back('{mk_tick(0, 0, 0, 0, 36, 0, 46, 2, 5), 1'b0, none});
    foreach (rows[i]) send_tick(rows[i].stim, rows[i].typed, rows[i].want);
    drain();

    // zero durations, open and closed thresholds, saturating time pick
    c = '{lf_thr: 8'd0, rf_thr: 8'd255, rear_thr: 8'd0, esc_straight: 8'd255,
          esc_side: 8'd0, search: 8'd1, rotate: 8'd0, attack: 8'd255};
    cfg_program(c);
    rows.delete();
    rows.push_back('{mk_tick(1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    rows.push_back('{mk_tick(0, 0, 0, 0, 0, 0, 0, 7, 63), 1'b0, none});
    rows.push_back('{mk_tick(0, 0, 0, 0, 0, 0, 1, 0, 0), 1'b0, none});
    rows.push_back('{mk_tick(0, 0, 0, 0, 0, 0, 0, 3, 40), 1'b0, none});
    rows.push_back('{mk_tick(0, 0, 0, 0, 1, 255, 0, 0, 0), 1'b0, none});
    rows.push_back('{mk_tick(0, 0, 0, 0, 0, 0, 0, 5, 0), 1'b0, none});
    rows.push_back('{mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 39), 1'b0, none});
    rows.push_back('{mk_tick(0, 0, 1, 1, 0, 0, 0, 0, 0), 1'b0, none});
    rows.push_back('{mk_tick(0, 0, 0, 0, 0, 0, 0, 6, 21), 1'b0, none});
    foreach (rows[i]) send_tick(rows[i].stim, rows[i].typed, rows[i].want);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: c = smsq_pkg::CFG_RESET;
        1: c = '{lf_thr: 8'd0, rf_thr: 8'd0, rear_thr: 8'd0, esc_straight: 8'd255,
                 esc_side: 8'd255, search: 8'd255, rotate: 8'd255, attack: 8'd255};
        2: c = '{lf_thr: 8'd255, rf_thr: 8'd255, rear_thr: 8'd255, esc_straight: 8'd0,
                 esc_side: 8'd0, search: 8'd0, rotate: 8'd0, attack: 8'd0};
        default: begin
          c.lf_thr       = 8'($urandom);
          c.rf_thr       = 8'($urandom);
          c.rear_thr     = 8'($urandom);
          c.esc_straight = 8'($urandom_range(20));
          c.esc_side     = 8'($urandom_range(20));
          c.search       = 8'($urandom_range(20));
          c.rotate       = 8'($urandom_range(20));
          c.attack       = 8'($urandom_range(20));
        end
      endcase
      cfg_program(c);
      tx_idle_pct = (p % 3 == 0) ? 17 : (p % 3 == 1) ? 67 : 0;
      rx_idle_pct = (p % 3 == 0) ? 67 : (p % 3 == 1) ? 17 : 0;
      repeat (PHASE_TICKS) send_tick(gen_tick(), 1'b0, none);
      drain();
    end

    if (pending_moves.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_moves.size()));
    $display("Run covered %0d tick requests under %0d register settings, %0d results checked",
             ticks_sent, settings_run, results_checked);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
